// File: design/apit_pkg.sv
// Shared types, widths and codes for the atom pair interaction term generator.
// No dependencies; every other design file depends on this package.
package apit_pkg;

    localparam int CoordW   = 16;           // Q8.8 coordinate
    localparam int DiffW    = CoordW + 1;   // coordinate difference
    localparam int SqW      = 32;           // one squared difference
    localparam int SumW     = 34;           // squared distance, Q16.16
    localparam int RootW    = 17;           // distance, Q8.8
    localparam int RemW     = 36;           // square root remainder / trial term
    localparam int IdxW     = 8;
    localparam int CoefW    = 48;
    localparam int MinW     = 16;
    localparam int StrW     = 32;
    localparam int QuotW    = 31;           // quotient bits before saturation
    localparam int Pow2W    = 2 * RootW;
    localparam int Pow3W    = 3 * RootW;
    localparam int PowW     = 6 * RootW;    // widest divisor, distance to the sixth
    localparam int SplitW   = 26;           // low slice used for the sixth power
    localparam int IsingSh  = 46;
    localparam int XySh     = 25;
    localparam int NumW     = CoefW + IsingSh;
    localparam int DivCmpW  = PowW + QuotW;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = CoefW;

    localparam logic [StrW-1:0] StrengthMax = 32'h7FFF_FFFF;

    localparam logic [CfgIdxW-1:0] RegMode = 2'd0;
    localparam logic [CfgIdxW-1:0] RegCoef = 2'd1;
    localparam logic [CfgIdxW-1:0] RegMin  = 2'd2;

    typedef enum logic {
        MODE_ISING = 1'b0,
        MODE_XY    = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        PAULI_I = 2'd0,
        PAULI_X = 2'd1,
        PAULI_Y = 2'd2,
        PAULI_Z = 2'd3
    } t_pauli;

    // Sideband that rides along with each pair through the pipeline.
    typedef struct packed {
        t_mode           mode;
        logic            too_close;
        logic [IdxW-1:0] idx_a;
        logic [IdxW-1:0] idx_b;
    } t_side;

endpackage

// File: design/apit_if.sv
// Valid/ready channel interfaces: pair input, term output and register writes.
// Depends on apit_pkg for field widths.
interface apit_pair_if;
    logic                                valid;
    logic                                ready;
    logic signed [apit_pkg::CoordW-1:0]  xa;
    logic signed [apit_pkg::CoordW-1:0]  ya;
    logic signed [apit_pkg::CoordW-1:0]  za;
    logic signed [apit_pkg::CoordW-1:0]  xb;
    logic signed [apit_pkg::CoordW-1:0]  yb;
    logic signed [apit_pkg::CoordW-1:0]  zb;
    logic        [apit_pkg::IdxW-1:0]    index_a;
    logic        [apit_pkg::IdxW-1:0]    index_b;

    modport source(output valid, xa, ya, za, xb, yb, zb, index_a, index_b, input ready);
    modport sink(input valid, xa, ya, za, xb, yb, zb, index_a, index_b, output ready);
endinterface

interface apit_term_if;
    logic                                valid;
    logic                                ready;
    logic        [1:0]                   pauli_a;
    logic        [1:0]                   pauli_b;
    logic        [apit_pkg::IdxW-1:0]    term_index_a;
    logic        [apit_pkg::IdxW-1:0]    term_index_b;
    logic signed [apit_pkg::StrW-1:0]    strength;
    logic                                too_close;
    logic                                last;

    modport source(output valid, pauli_a, pauli_b, term_index_a, term_index_b, strength,
                   too_close, last, input ready);
    modport sink(input valid, pauli_a, pauli_b, term_index_a, term_index_b, strength,
                 too_close, last, output ready);
endinterface

interface apit_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [apit_pkg::CfgIdxW-1:0]        index;
    logic [apit_pkg::CfgDataW-1:0]       data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: design/atom_pair_interaction_terms.sv
// Pairs enter one word per cycle while the pipeline is not stalled; terms leave one
// per cycle on the single term port: four per pair (Ising), two (XY) or one (too
// close). The pipeline stalls while the term buffer cannot take the next pair.
// Reset (synchronous, active low): pipeline valid bits and term buffer cleared,
// mode, coefficient and min_distance return to zero. Depends on apit_pkg, apit_if,
// apit_sqrt and apit_div.
module atom_pair_interaction_terms (
    input  logic  i_clk,
    input  logic  i_rst_n,
    apit_cfg_if.sink    i_cfg,
    apit_pair_if.sink   i_pair,
    apit_term_if.source o_term
);
    import apit_pkg::*;

    // configuration registers
    t_mode            r_mode;
    logic [CoefW-1:0] r_coef;
    logic [MinW-1:0]  r_min;

    // pipeline control: every stage moves together; it holds only when the last
    // divider stage has a word the term buffer cannot take
    logic en;
    logic div_v;
    logic x_free;
    logic x_last;

    // stage 1: differences
    logic                    r_v1;
    logic signed [DiffW-1:0] r_dx, r_dy, r_dz;
    t_side                   r_s1;
    // stage 2: squares
    logic                    r_v2;
    logic [SqW-1:0]          r_sqx, r_sqy, r_sqz;
    t_side                   r_s2;
    // stage 3: squared distance
    logic                    r_v3;
    logic [SumW-1:0]         r_sum;
    t_side                   r_s3;
    // sqrt output
    logic                    sq_v;
    logic [RootW-1:0]        sq_root;
    t_side                   sq_side;
    // stage 4: D^2, minimum check
    logic                    r_v4;
    logic [RootW-1:0]        r_root4;
    logic [Pow2W-1:0]        r_d2;
    t_side                   r_s4;
    // stage 5: D^3
    logic                    r_v5;
    logic [Pow3W-1:0]        r_d3;
    t_side                   r_s5;
    // stage 6: partial products of D^6 (D^3 split into high and low slices)
    logic                              r_v6;
    logic [Pow3W-1:0]                  r_d3b;
    logic [2*SplitW-1:0]               r_pp_ll;
    logic [Pow3W-1:0]                  r_pp_hl;
    logic [2*(Pow3W-SplitW)-1:0]       r_pp_hh;
    t_side                             r_s6;
    // stage 7: divider operands
    logic                    r_v7;
    logic [NumW-1:0]         r_num;
    logic [PowW-1:0]         r_den;
    logic                    r_zero;
    t_side                   r_s7;

    logic signed [2*DiffW-1:0]     px, py, pz;
    logic [PowW-1:0]               d6;

    logic [StrW-1:0] div_s;
    t_side           div_side;

    // term buffer (output register)
    logic            r_xv;
    logic [1:0]      r_xcnt;
    logic [StrW-1:0] r_xs;
    t_side           r_xside;
    t_pauli          pa, pb;
    logic            neg;

    // ---------------- configuration writes ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ISING;
            r_coef <= '0;
            r_min  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                RegMode: r_mode <= t_mode'(i_cfg.data[0]);
                RegCoef: r_coef <= i_cfg.data[CoefW-1:0];
                RegMin:  r_min  <= i_cfg.data[MinW-1:0];
                default: ;
            endcase
        end
    end

    assign en           = !div_v || x_free;
    assign i_pair.ready = en;

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_pair.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= sq_v;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    assign px    = r_dx * r_dx;
    assign py    = r_dy * r_dy;
    assign pz    = r_dz * r_dz;
    // D^6 = hh*2^52 + 2*hl*2^26 + ll
    assign d6    = PowW'(r_pp_ll) + (PowW'(r_pp_hl) << (SplitW + 1))
                 + (PowW'(r_pp_hh) << (2 * SplitW));

    // ---------------- datapath stages ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            // 1: sign-extended differences, mode sampled with the pair
            r_dx <= $signed({i_pair.xa[CoordW-1], i_pair.xa})
                  - $signed({i_pair.xb[CoordW-1], i_pair.xb});
            r_dy <= $signed({i_pair.ya[CoordW-1], i_pair.ya})
                  - $signed({i_pair.yb[CoordW-1], i_pair.yb});
            r_dz <= $signed({i_pair.za[CoordW-1], i_pair.za})
                  - $signed({i_pair.zb[CoordW-1], i_pair.zb});
            r_s1 <= {r_mode, 1'b0, i_pair.index_a, i_pair.index_b};
            // 2: squares, each below 2^32
            r_sqx <= px[SqW-1:0];
            r_sqy <= py[SqW-1:0];
            r_sqz <= pz[SqW-1:0];
            r_s2  <= r_s1;
            // 3: sum of squares
            r_sum <= SumW'(r_sqx) + SumW'(r_sqy) + SumW'(r_sqz);
            r_s3  <= r_s2;
            // 4: D^2 and minimum distance flag
            r_root4 <= sq_root;
            r_d2    <= Pow2W'(sq_root * sq_root);
            r_s4    <= {sq_side.mode, sq_root < RootW'(r_min), sq_side.idx_a, sq_side.idx_b};
            // 5: D^3
            r_d3 <= Pow3W'(r_d2 * r_root4);
            r_s5 <= r_s4;
            // 6: slice products of D^3 squared
            r_d3b   <= r_d3;
            r_pp_ll <= r_d3[SplitW-1:0] * r_d3[SplitW-1:0];
            r_pp_hl <= r_d3[Pow3W-1:SplitW] * r_d3[SplitW-1:0];
            r_pp_hh <= r_d3[Pow3W-1:SplitW] * r_d3[Pow3W-1:SplitW];
            r_s6    <= r_s5;
            // 7: finish D^6, pick operands for the mode
            if (r_s6.mode == MODE_XY) begin
                r_num <= NumW'(r_coef) << XySh;
                r_den <= PowW'(r_d3b);
            end else begin
                r_num <= NumW'(r_coef) << IsingSh;
                r_den <= d6;
            end
            r_zero <= r_coef == '0;
            r_s7   <= r_s6;
        end
    end

    apit_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v3),
        .i_radicand (r_sum),
        .i_side     (r_s3),
        .o_valid    (sq_v),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    apit_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v7),
        .i_num      (r_num),
        .i_den      (r_den),
        .i_zero     (r_zero),
        .i_side     (r_s7),
        .o_valid    (div_v),
        .o_strength (div_s),
        .o_side     (div_side)
    );

    // ---------------- term expansion ----------------
    // Ising: II +s, IZ -s, ZI -s, ZZ +s.  XY: XX +s, YY +s.
    // Too close: a single II word, zero strength, flagged.
    always_comb begin
        pa     = PAULI_I;
        pb     = PAULI_I;
        neg    = 1'b0;
        x_last = 1'b0;
        if (r_xside.too_close) begin
            x_last = 1'b1;
        end else if (r_xside.mode == MODE_XY) begin
            pa     = r_xcnt[0] ? PAULI_Y : PAULI_X;
            pb     = pa;
            x_last = r_xcnt[0];
        end else begin
            unique case (r_xcnt)
                2'd0: begin
                    pa = PAULI_I;
                    pb = PAULI_I;
                end
                2'd1: begin
                    pa  = PAULI_I;
                    pb  = PAULI_Z;
                    neg = 1'b1;
                end
                2'd2: begin
                    pa  = PAULI_Z;
                    pb  = PAULI_I;
                    neg = 1'b1;
                end
                default: begin
                    pa     = PAULI_Z;
                    pb     = PAULI_Z;
                    x_last = 1'b1;
                end
            endcase
        end
    end

    assign x_free = !r_xv || (o_term.ready && x_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv   <= 1'b0;
            r_xcnt <= '0;
        end else if (div_v && x_free) begin
            r_xv   <= 1'b1;
            r_xcnt <= '0;
        end else if (r_xv && o_term.ready) begin
            r_xv   <= !x_last;
            r_xcnt <= r_xcnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_v && x_free) begin
            r_xs    <= div_s;
            r_xside <= div_side;
        end
    end

    assign o_term.valid        = r_xv;
    assign o_term.pauli_a      = pa;
    assign o_term.pauli_b      = pb;
    assign o_term.term_index_a = r_xside.idx_a;
    assign o_term.term_index_b = r_xside.idx_b;
    assign o_term.strength     = r_xside.too_close ? '0 : (neg ? (StrW'(0) - r_xs) : r_xs);
    assign o_term.too_close    = r_xside.too_close;
    assign o_term.last         = x_last;

    // ---------------- checks ----------------
    a_close_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_term.valid && o_term.too_close |-> o_term.last && o_term.strength == '0)
        else $error("too-close word not a single zero term");

    a_xy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_xv && r_xside.mode == MODE_XY && !r_xside.too_close |-> r_xcnt[1] == 1'b0)
        else $error("XY pair produced more than two terms");

    a_term_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_xv && o_term.ready && !x_last |=> r_xv && r_xcnt == $past(r_xcnt) + 2'd1)
        else $error("term sequence skipped or dropped a word");

    a_neg_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_term.valid && !o_term.too_close && o_term.pauli_a != o_term.pauli_b
        |-> o_term.strength[StrW-1] || o_term.strength == '0)
        else $error("mixed Ising term not negative");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> div_v && r_xv)
        else $error("pipeline stalled with free term buffer");

endmodule

// File: design/apit_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on apit_pkg.
module apit_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [apit_pkg::SumW-1:0]  i_radicand,
    input  apit_pkg::t_side         i_side,
    output logic                    o_valid,
    output logic [apit_pkg::RootW-1:0] o_root,
    output apit_pkg::t_side         o_side
);
    import apit_pkg::*;

    logic             r_v    [1:RootW];
    logic [RemW-1:0]  r_rem  [1:RootW];
    logic [RootW-1:0] r_root [1:RootW];
    t_side            r_side [1:RootW];

    for (genvar k = 0; k < RootW; k++) begin : g_stage
        localparam int B = RootW - 1 - k;
        logic             v_in;
        logic [RemW-1:0]  rem_in;
        logic [RootW-1:0] root_in;
        t_side            side_in;
        logic [RemW-1:0]  trial;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = RemW'(i_radicand);
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k];
            assign rem_in  = r_rem[k];
            assign root_in = r_root[k];
            assign side_in = r_side[k];
        end

        // (root + 2^B)^2 - root^2
        assign trial = (RemW'(root_in) << (B + 1)) | (RemW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= side_in;
                if (rem_in >= trial) begin
                    r_rem[k+1]  <= rem_in - trial;
                    r_root[k+1] <= root_in | (RootW'(1) << B);
                end else begin
                    r_rem[k+1]  <= rem_in;
                    r_root[k+1] <= root_in;
                end
            end
        end
    end

    assign o_valid = r_v[RootW];
    assign o_root  = r_root[RootW];
    assign o_side  = r_side[RootW];

endmodule

// File: design/apit_div.sv
// Pipelined restoring divider with saturation to the positive Q16.16 limit.
// Depends on apit_pkg.
module apit_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [apit_pkg::NumW-1:0]   i_num,
    input  logic [apit_pkg::PowW-1:0]   i_den,
    input  logic                        i_zero,
    input  apit_pkg::t_side             i_side,
    output logic                        o_valid,
    output logic [apit_pkg::StrW-1:0]   o_strength,
    output apit_pkg::t_side             o_side
);
    import apit_pkg::*;

    logic             r_v    [0:QuotW];
    logic [NumW-1:0]  r_rem  [0:QuotW];
    logic [PowW-1:0]  r_den  [0:QuotW];
    logic [QuotW-1:0] r_q    [0:QuotW];
    logic             r_sat  [0:QuotW];
    logic             r_zero [0:QuotW];
    t_side            r_side [0:QuotW];

    // Stage 0: quotient overflows 31 bits (or divisor is zero)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_sat[0]  <= DivCmpW'(i_num) >= (DivCmpW'(i_den) << QuotW);
            r_zero[0] <= i_zero;
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 0; j < QuotW; j++) begin : g_stage
        localparam int B = QuotW - 1 - j;
        logic [DivCmpW-1:0] shifted;
        logic               take;

        assign shifted = DivCmpW'(r_den[j]) << B;
        assign take    = DivCmpW'(r_rem[j]) >= shifted;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= take ? (r_rem[j] - shifted[NumW-1:0]) : r_rem[j];
                r_q[j+1]    <= r_q[j] | (take ? (QuotW'(1) << B) : '0);
                r_den[j+1]  <= r_den[j];
                r_sat[j+1]  <= r_sat[j];
                r_zero[j+1] <= r_zero[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_valid    = r_v[QuotW];
    assign o_side     = r_side[QuotW];
    assign o_strength = r_zero[QuotW] ? '0
                      : (r_sat[QuotW] ? StrengthMax : {1'b0, r_q[QuotW]});

endmodule

// File: test/apit_tb_if.sv
`timescale 1ns / 100ps
// Testbench copy marker: the channel interfaces live in design/apit_if.sv.
// Depends on apit_pkg; this file only holds shared testbench types.
package apit_tb_pkg;
    import apit_pkg::*;

    // One expected term word.
    typedef struct packed {
        t_pauli             pa;
        t_pauli             pb;
        logic [IdxW-1:0]    ia;
        logic [IdxW-1:0]    ib;
        logic [StrW-1:0]    strength;
        logic               too_close;
        logic               last;
    } t_term_exp;
endpackage

// File: test/atom_pair_interaction_terms_tb.sv
`timescale 1ns / 100ps
// Testbench for atom_pair_interaction_terms: random and directed atom pairs,
// predicted term words checked in order. Depends on apit_pkg, apit_if, apit_tb_pkg.
module atom_pair_interaction_terms_tb;
    import apit_pkg::*;
    import apit_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    apit_cfg_if  cfg_ch();
    apit_pair_if pair_ch();
    apit_term_if term_ch();

    atom_pair_interaction_terms u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_pair  (pair_ch.sink),
        .o_term  (term_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the register file.
    t_mode             cur_mode;
    logic [CoefW-1:0]  cur_coef;
    logic [MinW-1:0]   cur_min;

    t_term_exp expected_terms[$];
    int        n_errors;
    int        n_terms;
    int        n_pairs;
    int        n_close;
    bit        stall_enable;

    // floor(sqrt(v)) for a squared distance.
    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 36;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // floor(coef * 2^sh / d^pw), clipped to the strength ceiling.
    function automatic logic [31:0] coupling(logic [CoefW-1:0] coef, int sh,
                                             logic [63:0] d, int pw);
        logic [191:0] num;
        logic [191:0] den;
        if (coef == 0) return 32'd0;
        if (d == 0) return StrengthMax;
        num = {144'd0, coef} << sh;
        den = 192'd1;
        for (int p = 0; p < pw; p++) den = den * d;
        num = num / den;
        if (num > StrengthMax) return StrengthMax;
        return num[31:0];
    endfunction

    function automatic t_term_exp mk_term(t_pauli pa, t_pauli pb, logic [7:0] ia,
                                          logic [7:0] ib, logic [31:0] s,
                                          logic tc, logic lst);
        t_term_exp t;
        t.pa = pa; t.pb = pb; t.ia = ia; t.ib = ib;
        t.strength = s; t.too_close = tc; t.last = lst;
        return t;
    endfunction

    // Push the terms that one pair produces under the current registers.
    task automatic predict_terms(logic signed [15:0] xa, ya, za, xb, yb, zb,
                                 logic [7:0] ia, ib);
        logic signed [63:0] dx, dy, dz;
        logic [63:0] d;
        logic [31:0] s;
        dx = 64'(xa) - 64'(xb);
        dy = 64'(ya) - 64'(yb);
        dz = 64'(za) - 64'(zb);
        d = int_root(dx * dx + dy * dy + dz * dz);
        if (d < cur_min) begin
            n_close++;
            expected_terms.push_back(mk_term(PAULI_I, PAULI_I, ia, ib, 0, 1, 1));
        end else if (cur_mode == MODE_ISING) begin
            s = coupling(cur_coef, IsingSh, d, 6);
            expected_terms.push_back(mk_term(PAULI_I, PAULI_I, ia, ib, s, 0, 0));
            expected_terms.push_back(mk_term(PAULI_I, PAULI_Z, ia, ib, -s, 0, 0));
            expected_terms.push_back(mk_term(PAULI_Z, PAULI_I, ia, ib, -s, 0, 0));
            expected_terms.push_back(mk_term(PAULI_Z, PAULI_Z, ia, ib, s, 0, 1));
        end else begin
            s = coupling(cur_coef, XySh, d, 3);
            expected_terms.push_back(mk_term(PAULI_X, PAULI_X, ia, ib, s, 0, 0));
            expected_terms.push_back(mk_term(PAULI_Y, PAULI_Y, ia, ib, s, 0, 1));
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR term %0d: %s got %0h want %0h", n_terms, what, got, want);
        n_errors++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Term sink: random stalls, compare each accepted word against the oldest one.
    initial begin
        int stall;
        t_term_exp w;
        term_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (term_ch.valid && term_ch.ready) begin
                if (expected_terms.size() == 0) begin
                    report_mismatch("unexpected word", 64'(term_ch.strength), 64'd0);
                end else begin
                    w = expected_terms.pop_front();
                    if (term_ch.pauli_a !== w.pa)
                        report_mismatch("pauli_a", 64'(term_ch.pauli_a), 64'(w.pa));
                    if (term_ch.pauli_b !== w.pb)
                        report_mismatch("pauli_b", 64'(term_ch.pauli_b), 64'(w.pb));
                    if (term_ch.term_index_a !== w.ia)
                        report_mismatch("term_index_a", 64'(term_ch.term_index_a), 64'(w.ia));
                    if (term_ch.term_index_b !== w.ib)
                        report_mismatch("term_index_b", 64'(term_ch.term_index_b), 64'(w.ib));
                    if (term_ch.strength !== w.strength)
                        report_mismatch("strength", 64'(term_ch.strength), 64'(w.strength));
                    if (term_ch.too_close !== w.too_close)
                        report_mismatch("too_close", 64'(term_ch.too_close), 64'(w.too_close));
                    if (term_ch.last !== w.last)
                        report_mismatch("last", 64'(term_ch.last), 64'(w.last));
                end
                n_terms++;
            end
            if (stall > 0) begin
                stall--;
                term_ch.ready <= 1'b0;
            end else if (stall_enable && $urandom_range(0, 3) == 0) begin
                stall = gap_len();
                term_ch.ready <= 1'b0;
            end else begin
                term_ch.ready <= 1'b1;
            end
        end
    end

    // Register write, only while the block is idle; valid is dropped by set_regs.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            RegMode: cur_mode = t_mode'(val[0]);
            RegCoef: cur_coef = val[CoefW-1:0];
            RegMin:  cur_min  = val[MinW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(t_mode m, logic [CoefW-1:0] c, logic [MinW-1:0] md);
        write_reg(RegMode, CfgDataW'(m));
        write_reg(RegCoef, c);
        write_reg(RegMin, CfgDataW'(md));
        cfg_ch.valid <= 1'b0;
    endtask

    // Send one pair word, optionally after a random gap; valid stays up afterwards.
    task automatic send_pair(logic signed [15:0] xa, ya, za, xb, yb, zb,
                             logic [7:0] ia, ib, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            pair_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        pair_ch.valid   <= 1'b1;
        pair_ch.xa <= xa; pair_ch.ya <= ya; pair_ch.za <= za;
        pair_ch.xb <= xb; pair_ch.yb <= yb; pair_ch.zb <= zb;
        pair_ch.index_a <= ia;
        pair_ch.index_b <= ib;
        do @(posedge i_clk); while (!pair_ch.ready);
        predict_terms(xa, ya, za, xb, yb, zb, ia, ib);
        n_pairs++;
    endtask

    // Wait for every expected term, then let the pipeline drain.
    task automatic drain();
        pair_ch.valid <= 1'b0;
        while (expected_terms.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Mostly short separations so strengths are neither zero nor clipped.
    task automatic send_random_pair(bit gaps);
        logic signed [15:0] xa, ya, za;
        int sel;
        sel = $urandom_range(0, 9);
        xa = 16'($urandom); ya = 16'($urandom); za = 16'($urandom);
        if (sel < 7)
            send_pair(xa, ya, za,
                      xa + 16'($signed($urandom_range(0, 4095)) - 2048),
                      ya + 16'($signed($urandom_range(0, 4095)) - 2048),
                      za + 16'($signed($urandom_range(0, 4095)) - 2048),
                      8'($urandom), 8'($urandom), gaps);
        else
            send_pair(xa, ya, za, 16'($urandom), 16'($urandom), 16'($urandom),
                      8'($urandom), 8'($urandom), gaps);
    endtask

    task automatic test_reset_defaults();
        // Registers at reset: Ising, zero coefficient, no minimum.
        send_pair(16'sd256, 0, 0, 0, 0, 0, 8'd0, 8'd1, 0);
        drain();
    endtask

    task automatic test_directed();
        // Extremes of coordinates and indices, both modes.
        set_regs(MODE_ISING, 48'h0000_0001_0000, 16'd0);
        send_pair(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
                  8'hFF, 8'h00, 0);
        send_pair(16'sd256, 0, 0, 0, 0, 0, 8'h00, 8'hFF, 0);
        // Coincident atoms saturate.
        send_pair(16'sd100, -16'sd7, 16'sd3, 16'sd100, -16'sd7, 16'sd3, 8'd5, 8'd5, 0);
        send_pair(16'sd64, 16'sd64, 0, 0, 0, 0, 8'd2, 8'd3, 0);
        drain();
        set_regs(MODE_XY, 48'hFFFF_FFFF_FFFF, 16'd0);
        send_pair(0, 0, 0, 0, 0, 0, 8'd1, 8'd2, 0);
        send_pair(16'sh7FFF, 0, 0, 16'sh8000, 0, 0, 8'd9, 8'd8, 0);
        send_pair(16'sd512, 16'sd512, 16'sd512, 0, 0, 0, 8'd7, 8'd6, 0);
        drain();
        set_regs(MODE_XY, 48'd0, 16'd0);
        send_pair(16'sd256, 0, 0, 0, 0, 0, 8'd1, 8'd1, 0);
        drain();
        // Too close, including minimum at its top value.
        set_regs(MODE_ISING, 48'h0000_0010_0000, 16'd512);
        send_pair(16'sd100, 0, 0, 0, 0, 0, 8'd4, 8'd200, 0);
        send_pair(16'sd512, 0, 0, 0, 0, 0, 8'd4, 8'd201, 0);
        send_pair(16'sd511, 0, 0, 0, 0, 0, 8'd4, 8'd202, 0);
        drain();
        set_regs(MODE_XY, 48'h0000_0010_0000, 16'hFFFF);
        send_pair(16'sh7FFF, 16'sh7FFF, 0, 16'sh8000, 16'sh8000, 0, 8'd33, 8'd44, 0);
        send_pair(0, 0, 0, 0, 0, 0, 8'd0, 8'd0, 0);
        drain();
    endtask

    task automatic test_random_phase(t_mode m, int n);
        logic [CoefW-1:0] c;
        case ($urandom_range(0, 3))
            0: c = 48'({$urandom, $urandom});
            1: c = 48'($urandom_range(1, 65535)) << $urandom_range(0, 32);
            default: c = 48'($urandom) << 8;
        endcase
        set_regs(m, c, 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 2048) : 0));
        for (int k = 0; k < n; k++) begin
            send_random_pair(1);
            // Hold off until the block is empty now and then.
            if (k == n / 2) begin
                pair_ch.valid <= 1'b0;
                while (expected_terms.size() != 0) @(posedge i_clk);
            end
        end
        drain();
    endtask

    task automatic test_back_to_back();
        // No idling on either side.
        stall_enable = 0;
        set_regs(MODE_ISING, 48'h0000_4000_0000, 16'd128);
        for (int k = 0; k < 30; k++) send_random_pair(0);
        drain();
        stall_enable = 1;
    endtask

    initial begin
        n_errors = 0; n_terms = 0; n_pairs = 0; n_close = 0;
        stall_enable = 1;
        cur_mode = MODE_ISING; cur_coef = 0; cur_min = 0;
        cfg_ch.valid = 1'b0; cfg_ch.index = RegMode; cfg_ch.data = '0;
        pair_ch.valid = 1'b0;
        pair_ch.xa = 0; pair_ch.ya = 0; pair_ch.za = 0;
        pair_ch.xb = 0; pair_ch.yb = 0; pair_ch.zb = 0;
        pair_ch.index_a = 0; pair_ch.index_b = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_back_to_back();
        for (int ph = 0; ph < 8; ph++) test_random_phase(t_mode'(ph[0]), 45);
        $display("Covered %0d pairs and %0d term words, %0d too close, both modes.",
                 n_pairs, n_terms, n_close);
        if (n_errors == 0 && expected_terms.size() == 0)
            $display("PASS atom_pair_interaction_terms");
        else
            $display("FAIL atom_pair_interaction_terms");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL atom_pair_interaction_terms");
        $finish;
    end
endmodule

// File: atom_pair_interaction_terms.f
design/apit_pkg.sv
design/apit_if.sv
design/apit_sqrt.sv
design/apit_div.sv
design/atom_pair_interaction_terms.sv
test/apit_tb_if.sv
test/atom_pair_interaction_terms_tb.sv
